// File: hw/rtl/scp_pkg.sv
package scp_pkg;

  localparam int LINE_MAX_DEF = 6;
  localparam int MOVE_LEN     = 5;
  localparam int SWITCH_LEN   = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MOVE  = 8'h4D;
  localparam logic [7:0] CH_ON    = 8'h4F;
  localparam logic [7:0] CH_OFF   = 8'h6F;

  localparam logic [7:0] POS_RESET = 8'd128;
  localparam logic [3:0] EN_RESET  = 4'hF;

  localparam int TX_W   = 8;
  localparam int OUT_W  = 48;
  localparam int PTR_W  = 7;

  // reply texts, each block ends with the prompt
  localparam int TEXT_LEN = 126;
  localparam logic [8*TEXT_LEN-1:0] TEXT = {
    "\015\012Sintassi errata",
    "\015\012Servo azionato",
    "\015\012SERVO> ",
    "Sintassi errata",
    "\015\012Stato del servo modificato",
    "\015\012SERVO> ",
    "\015\012Comando sconosciuto\015\012",
    "\015\012SERVO> "
  };

  localparam logic [PTR_W-1:0] MOVE_BAD = 7'd0;
  localparam logic [PTR_W-1:0] MOVE_OK  = 7'd17;
  localparam logic [PTR_W-1:0] MOVE_END = 7'd41;
  localparam logic [PTR_W-1:0] SW_BAD   = 7'd42;
  localparam logic [PTR_W-1:0] SW_OK    = 7'd57;
  localparam logic [PTR_W-1:0] SW_END   = 7'd93;
  localparam logic [PTR_W-1:0] UNK_BEG  = 7'd94;
  localparam logic [PTR_W-1:0] UNK_END  = 7'd125;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_TEXT
  } state_t;

  typedef struct packed {
    logic store;
    logic parse;
    logic advance;
    logic sel_echo;
  } ctrl_cmd_t;

  typedef struct packed {
    logic store_ok;
    logic line_open;
    logic has_reply;
    logic text_last;
  } ctrl_status_t;

  function automatic logic [7:0] text_byte(input logic [PTR_W-1:0] idx);
    logic [8*TEXT_LEN-1:0] w;
    w = TEXT >> (8 * (TEXT_LEN - 1 - int'(idx)));
    return w[7:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: hw/rtl/servo_command_line_parser_unit.sv
// servo command line parser
// slave stream s_*: one received serial character per request (s_tdata[7:0])
// master stream m_*: characters to transmit, echo or reply text, with tlast
//   on the last character caused by a request; tdata also carries the servo
//   enable mask and the four stored servo positions after that request
// an ordinary character is stored and echoed: one output, valid in the
//   cycle after acceptance
// cr, lf or a character on a full line closes a non-empty line: a reply of 0 to 52
//   characters follows, one per cycle while the sink is ready, from the text rom read
//   pointer, the first in the cycle after acceptance
// s_tready is low while output is pending, so the line-to-reply sequencer
//   handles one request at a time
// a stalled sink holds the current character and all of tdata steady
// reset: line empty, positions 128, enable mask all ones, no output pending
module servo_command_line_parser_unit #(
  parameter int LINE_MAX = scp_pkg::LINE_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,  // rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [scp_pkg::OUT_W-1:0] m_tdata,  // tx_byte, enable_mask, servo0..3_position
  output logic                      m_tlast   // is_last
);
  import scp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  scp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  scp_datapath #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// File: hw/rtl/scp_ctrl.sv
module scp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  scp_pkg::ctrl_status_t status,
  output scp_pkg::ctrl_cmd_t    cmd
);
  import scp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.store_ok) begin
            state_next = ST_ECHO;
          end else if (status.line_open && status.has_reply) begin
            state_next = ST_TEXT;
          end
        end
      end
      ST_ECHO: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      ST_TEXT: begin
        if (m_tready && status.text_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        cmd.store = s_tvalid && status.store_ok;
        cmd.parse = s_tvalid && !status.store_ok && status.line_open;
      end
      ST_ECHO: begin
        m_tvalid     = 1'b1;
        cmd.sel_echo = 1'b1;
      end
      ST_TEXT: begin
        m_tvalid    = 1'b1;
        cmd.advance = m_tready && !status.text_last;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/scp_datapath.sv
module scp_datapath #(
  parameter int LINE_MAX = scp_pkg::LINE_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 s_tdata,
  input  scp_pkg::ctrl_cmd_t          cmd,
  output scp_pkg::ctrl_status_t       status,
  output logic [scp_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast
);
  import scp_pkg::*;

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam int IW = $clog2(LINE_MAX);

  logic [7:0]       line_store [LINE_MAX];
  logic [CW-1:0]    line_count;
  logic [7:0]       servo_position [4];
  logic [3:0]       servo_enable;
  logic [7:0]       echo_byte;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_end;

  logic [7:0]       head;
  logic             is_move, move_ok, is_sw, sw_digit, sw_ok;
  logic [3:0]       dig_d, dig_a, dig_b, dig_c, dig_n;
  logic [9:0]       pos_full;
  logic [7:0]       pos_clamp;
  logic [1:0]       servo_sel;
  logic [PTR_W-1:0] reply_start, reply_end;
  logic [7:0]       tx_byte;

  // line decode
  always_comb begin
    head     = line_store[0];
    dig_d    = 4'(line_store[1] - CH_ZERO);
    dig_a    = 4'(line_store[2] - CH_ZERO);
    dig_b    = 4'(line_store[3] - CH_ZERO);
    dig_c    = 4'(line_store[4] - CH_ZERO);
    dig_n    = dig_d;
    is_move  = (head == CH_MOVE) && (line_count == CW'(MOVE_LEN));
    move_ok  = is_digit(line_store[1]) && is_digit(line_store[2]) &&
               is_digit(line_store[3]) && is_digit(line_store[4]);
    is_sw    = ((head == CH_ON) || (head == CH_OFF)) && (line_count == CW'(SWITCH_LEN));
    sw_digit = is_digit(line_store[1]);
    sw_ok    = sw_digit && (dig_n <= 4'd3);
    pos_full = 10'(dig_a) * 10'd100 + 10'(dig_b) * 10'd10 + 10'(dig_c);
    pos_clamp = (pos_full > 10'd255) ? 8'hFF : pos_full[7:0];
    servo_sel = (dig_d > 4'd3) ? 2'd3 : dig_d[1:0];
    if (is_move) begin
      reply_start = move_ok ? MOVE_OK : MOVE_BAD;
      reply_end   = MOVE_END;
    end else if (is_sw) begin
      reply_start = sw_ok ? SW_OK : SW_BAD;
      reply_end   = SW_END;
    end else begin
      reply_start = UNK_BEG;
      reply_end   = UNK_END;
    end
  end

  assign status.store_ok  = (s_tdata != CH_CR) && (s_tdata != CH_LF) &&
                            (line_count < CW'(LINE_MAX));
  assign status.line_open = (line_count != '0);
  assign status.has_reply = !(is_sw && !sw_digit);
  assign status.text_last = (ptr == ptr_end);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_store[line_count[IW-1:0]] <= s_tdata;
      echo_byte <= s_tdata;
    end
    if (cmd.parse) begin
      ptr     <= reply_start;
      ptr_end <= reply_end;
    end else if (cmd.advance) begin
      ptr <= ptr + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      servo_enable <= EN_RESET;
      for (int i = 0; i < 4; i++) begin
        servo_position[i] <= POS_RESET;
      end
    end else begin
      if (cmd.store) begin
        line_count <= line_count + CW'(1);
      end else if (cmd.parse) begin
        line_count <= '0;
        if (is_move && move_ok) begin
          servo_position[servo_sel] <= pos_clamp;
        end
        if (is_sw && sw_ok) begin
          if (head == CH_ON) begin
            servo_enable <= servo_enable | (4'b0001 << dig_n[1:0]);
          end else begin
            servo_enable <= servo_enable & ~(4'b0001 << dig_n[1:0]);
          end
        end
      end
    end
  end

  assign tx_byte = cmd.sel_echo ? echo_byte : text_byte(ptr);
  assign m_tlast = cmd.sel_echo || status.text_last;
  assign m_tdata = {4'b0000, servo_position[3], servo_position[2], servo_position[1],
                    servo_position[0], servo_enable, tx_byte};

endmodule

// File: hw/rtl/scp_checker.sv
module scp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [scp_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  // input side open exactly when no output is pending
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    s_tready != m_tvalid)
    else $error("input ready while output pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("input not reopened after last character");

  a_state_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[scp_pkg::OUT_W-1:8]))
    else $error("servo state changed within a reply");

  // no output appears without an accepted request
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("output without request");

endmodule

bind servo_command_line_parser_unit scp_checker u_scp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
